@@ rtl/core/bptc_pkg.sv @@
// Shared constants and types for the pressure/temperature compensation unit.
// No dependencies.
`timescale 1ns / 1ps
package bptc_pkg;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int DIV_W           = 32;
	localparam int UT_W            = 16;
	localparam int UP_W            = 24;
	localparam int TEMP_W          = 12;
	localparam int PRES_W          = 17;

	localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
	localparam logic signed [31:0] P_C1       = 32'sd3038;
	localparam logic signed [31:0] P_C2       = -32'sd7357;
	localparam logic signed [31:0] P_C3       = 32'sd3791;
	localparam logic signed [31:0] B4_OFFSET  = 32'sd32768;
	localparam logic [15:0]        B7_SCALE   = 16'd50000;
	localparam logic [31:0]        B7_MSB     = 32'h80000000;
	localparam logic signed [31:0] TEMP_MAX   = 32'sd2047;
	localparam logic signed [31:0] TEMP_MIN   = -32'sd2048;
	localparam logic signed [31:0] PRES_MAX   = 32'sd131071;

	typedef enum logic [1:0] {
		CFG_COEFF_A = 2'd0,
		CFG_COEFF_B = 2'd1,
		CFG_COEFF_C = 2'd2,
		CFG_OSS     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic [15:0]        ac4;
		logic [15:0]        ac5;
		logic [15:0]        ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
		logic [1:0]         oss;
	} calib_t;
endpackage

@@ rtl/core/baro_pressure_temp_compensation_unit.sv @@
// Barometric compensation top: config registers, front queue, back datapath.
// After the queue, a reading passes 11 datapath stages, two 32-stage
// dividers and the output register.
// Throughput: one reading per cycle, set by the fully pipelined dividers.
// Stalls only when the result register is held; arst_n clears all valids
// and calibration registers to zero.
`timescale 1ns / 1ps
module baro_pressure_temp_compensation_unit
	import bptc_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [UT_W-1:0]   raw_temperature,
	input  logic [UP_W-1:0]   raw_pressure_bytes,
	output logic              empty,
	input  logic              pop,
	output logic [TEMP_W-1:0] temperature_tenths,
	output logic [PRES_W-1:0] pressure_pa,
	output logic              divide_fault,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	logic [63:0] coeff_a_q, coeff_b_q;
	logic [31:0] coeff_c_q;
	logic [1:0]  oss_q;
	calib_t      cal;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_q <= '0;
			coeff_b_q <= '0;
			coeff_c_q <= '0;
			oss_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COEFF_A: coeff_a_q <= cfg_data;
				CFG_COEFF_B: coeff_b_q <= cfg_data;
				CFG_COEFF_C: coeff_c_q <= cfg_data[31:0];
				CFG_OSS:     oss_q     <= cfg_data[1:0];
				default:     ;
			endcase
		end
	end

	assign cal = '{ac1: coeff_a_q[63:48], ac2: coeff_a_q[47:32], ac3: coeff_a_q[31:16],
		ac4: coeff_a_q[15:0], ac5: coeff_b_q[63:48], ac6: coeff_b_q[47:32],
		b1: coeff_b_q[31:16], b2: coeff_b_q[15:0], mc: coeff_c_q[31:16],
		md: coeff_c_q[15:0], oss: oss_q};

	// front: align pressure word and queue the reading
	logic [UP_W-1:0]      up;
	logic [UT_W-1:0]      q_ut;
	logic [UP_W-1:0]      q_up;
	logic                 q_empty;
	logic                 en;
	logic                 res_v_q;
	logic [TEMP_W-1:0]    res_t_q;
	logic [PRES_W-1:0]    res_p_q;
	logic                 res_f_q;
	logic                 b_v, b_f;
	logic [TEMP_W-1:0]    b_t;
	logic [PRES_W-1:0]    b_p;

	assign up = raw_pressure_bytes >> (4'd8 - {2'b0, oss_q});
	assign en = !res_v_q || pop;

	bptc_queue #(.W(UT_W + UP_W), .DEPTH(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(push), .wdata({raw_temperature, up}),
		.rd(en), .rdata({q_ut, q_up}),
		.full(full), .empty(q_empty)
	);

	bptc_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(!q_empty),
		.ut(q_ut), .up(q_up), .cal(cal),
		.out_v(b_v), .temp(b_t), .pres(b_p), .fault(b_f)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (en) res_v_q <= b_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_t_q <= b_t;
			res_p_q <= b_p;
			res_f_q <= b_f;
		end
	end

	assign empty              = !res_v_q;
	assign temperature_tenths = res_t_q;
	assign pressure_pa        = res_p_q;
	assign divide_fault       = res_f_q;
endmodule

@@ rtl/core/bptc_queue.sv @@
// Small register FIFO between front and back.
// Depends on nothing.
`timescale 1ns / 1ps
module bptc_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			if (do_rd) rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wdata;
	end
endmodule

@@ rtl/core/bptc_divider.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on nothing; carries a sideband word alongside.
`timescale 1ns / 1ps
module bptc_divider #(
	parameter int W  = 32,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [SW-1:0] side_in,
	output logic          out_v,
	output logic [W-1:0]  quo,
	output logic [SW-1:0] side_out
);
	logic [W:0]    rem_q  [W+1];
	logic [W-1:0]  nq_q   [W+1];
	logic [W-1:0]  den_q  [W+1];
	logic [SW-1:0] side_q [W+1];
	logic          v_q    [W+1];

	assign rem_q[0]  = '0;
	assign nq_q[0]   = num;
	assign den_q[0]  = den;
	assign side_q[0] = side_in;
	assign v_q[0]    = in_v;

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W:0] trial;
		logic       ge;
		assign trial = {rem_q[i][W-1:0], nq_q[i][W-1]};
		assign ge    = (trial >= {1'b0, den_q[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i+1] <= 1'b0;
			else if (en) v_q[i+1] <= v_q[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1]  <= ge ? trial - {1'b0, den_q[i]} : trial;
				nq_q[i+1]   <= {nq_q[i][W-2:0], ge};
				den_q[i+1]  <= den_q[i];
				side_q[i+1] <= side_q[i];
			end
		end
	end

	assign out_v    = v_q[W];
	assign quo      = nq_q[W];
	assign side_out = side_q[W];
endmodule

@@ rtl/core/bptc_back.sv @@
// Compensation datapath: multiply stages and two pipelined dividers.
// Depends on bptc_pkg and bptc_divider.
`timescale 1ns / 1ps
module bptc_back
	import bptc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [UT_W-1:0]   ut,
	input  logic [UP_W-1:0]   up,
	input  calib_t            cal,
	output logic              out_v,
	output logic [TEMP_W-1:0] temp,
	output logic [PRES_W-1:0] pres,
	output logic              fault
);
	localparam int S1W = 2 + 32 + UP_W;
	localparam int S2W = 2 + TEMP_W;

	logic               v_s1, v_s2, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic               v_s10, v_s11, v_s12;
	logic signed [31:0] a_s1;
	logic [UP_W-1:0]    up_s1, up_s2, up_s4, up_s5, up_s6, up_s7;
	logic signed [31:0] x1t_s2, d_s2;

	logic signed [16:0] diff;
	logic signed [33:0] prod1;
	logic signed [31:0] x1t;

	assign diff  = $signed({1'b0, ut}) - $signed({1'b0, cal.ac6});
	assign prod1 = diff * $signed({1'b0, cal.ac5});
	assign x1t   = a_s1 >>> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= prod1[31:0];
			up_s1  <= up;
			x1t_s2 <= x1t;
			d_s2   <= x1t + {{16{cal.md[15]}}, cal.md};
			up_s2  <= up_s1;
		end
	end

	// first divider: mc * 2048 / (x1 + md), truncated toward zero
	logic signed [31:0] num1;
	logic [31:0]        nmag1, dmag1, q1;
	logic [S1W-1:0]     side1_in, side1_out;
	logic               v_d1;

	assign num1     = {{5{cal.mc[15]}}, cal.mc, 11'b0};
	assign nmag1    = num1[31] ? 32'(-num1) : num1;
	assign dmag1    = d_s2[31] ? 32'(-d_s2) : d_s2;
	assign side1_in = {(d_s2 == 32'sd0), num1[31] ^ d_s2[31], x1t_s2, up_s2};

	bptc_divider #(.W(DIV_W), .SW(S1W)) u_div1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s2),
		.num(nmag1), .den(dmag1), .side_in(side1_in),
		.out_v(v_d1), .quo(q1), .side_out(side1_out)
	);

	logic               f1;
	logic               neg1;
	logic signed [31:0] x1d, x2, b5, tw;
	logic [UP_W-1:0]    upd;

	assign {f1, neg1, x1d, upd} = side1_out;
	assign x2 = neg1 ? $signed(-q1) : $signed(q1);
	assign b5 = x1d + x2;
	assign tw = (b5 + 32'sd8) >>> 4;

	logic signed [31:0]       b6_s4;
	logic [TEMP_W-1:0]        t_s4, t_s5, t_s6, t_s7, t_s8, t_s9;
	logic                     f_s4, f_s5, f_s6, f_s7, f_s8;
	logic signed [31:0]       p66_s5, m2_s5, m3_s5;
	logic signed [31:0]       mb2_s6, mb1_s6, m2_s6, m3_s6;
	logic signed [31:0]       b3_s7, s_s7;
	logic [31:0]              p4_s8, b7_s8;
	logic [31:0]              dvd_s9, b4_s9;
	logic                     f_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_d1;
	end

	logic signed [63:0] p66_w;
	logic signed [47:0] m2_w, m3_w, mb2_w, mb1_w;
	logic signed [31:0] b6sq;
	logic signed [31:0] x3a, b3a, b3b, x3b;
	logic [47:0]        p4_w, b7_w;
	logic [31:0]        upmb3;
	logic [16:0]        b4;

	assign p66_w = b6_s4 * b6_s4;
	assign m2_w  = b6_s4 * cal.ac2;
	assign m3_w  = b6_s4 * cal.ac3;
	assign b6sq  = p66_s5 >>> 12;
	assign mb2_w = b6sq * cal.b2;
	assign mb1_w = b6sq * cal.b1;
	assign x3a   = (mb2_s6 >>> 11) + (m2_s6 >>> 11);
	assign b3a   = {{14{cal.ac1[15]}}, cal.ac1, 2'b0} + x3a;
	assign b3b   = b3a <<< cal.oss;
	assign x3b   = ((m3_s6 >>> 13) + (mb1_s6 >>> 16) + 32'sd2) >>> 2;
	assign upmb3 = {{(32-UP_W){1'b0}}, up_s7} - b3_s7;
	assign p4_w  = {16'b0, s_s7} * {32'b0, cal.ac4};
	assign b7_w  = {16'b0, upmb3} * {32'b0, B7_SCALE >> cal.oss};
	assign b4    = p4_s8[31:15];

	always_ff @(posedge clk) begin
		if (en) begin
			b6_s4 <= b5 - B6_OFFSET;
			f_s4  <= f1;
			up_s4 <= upd;
			if (tw > TEMP_MAX) t_s4 <= TEMP_MAX[TEMP_W-1:0];
			else if (tw < TEMP_MIN) t_s4 <= TEMP_MIN[TEMP_W-1:0];
			else t_s4 <= tw[TEMP_W-1:0];

			p66_s5 <= p66_w[31:0];
			m2_s5  <= m2_w[31:0];
			m3_s5  <= m3_w[31:0];
			t_s5 <= t_s4; f_s5 <= f_s4; up_s5 <= up_s4;

			mb2_s6 <= mb2_w[31:0];
			mb1_s6 <= mb1_w[31:0];
			m2_s6  <= m2_s5;
			m3_s6  <= m3_s5;
			t_s6 <= t_s5; f_s6 <= f_s5; up_s6 <= up_s5;

			b3_s7 <= (b3b + 32'sd2) >>> 2;
			s_s7  <= x3b + B4_OFFSET;
			t_s7 <= t_s6; f_s7 <= f_s6; up_s7 <= up_s6;

			p4_s8 <= p4_w[31:0];
			b7_s8 <= b7_w[31:0];
			t_s8 <= t_s7; f_s8 <= f_s7;

			b4_s9  <= {15'b0, b4};
			dvd_s9 <= b7_s8[31] ? b7_s8 : {b7_s8[30:0], 1'b0};
			f_s9   <= f_s8 || (b4 == 17'd0);
			t_s9   <= t_s8;
		end
	end

	// second divider: 2*b7 / b4, or b7 / b4 when the MSB of b7 is set
	logic [31:0]    q2;
	logic [S2W-1:0] side2_out;
	logic           v_d2, f2, msb2;
	logic [TEMP_W-1:0] t2;
	logic b7_s8_msb_s9;

	always_ff @(posedge clk) begin
		if (en) b7_s8_msb_s9 <= b7_s8[31];
	end

	bptc_divider #(.W(DIV_W), .SW(S2W)) u_div2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s9),
		.num(dvd_s9), .den(b4_s9), .side_in({f_s9, t_s9, b7_s8_msb_s9}),
		.out_v(v_d2), .quo(q2), .side_out(side2_out)
	);

	assign {f2, t2, msb2} = side2_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (en) v_s10 <= v_d2;
	end

	logic signed [31:0] p_s10, p_s11, p_s12;
	logic signed [31:0] x1sq_s11, m_s11, y1_s12, x2_s12;
	logic [TEMP_W-1:0]  t_s10, t_s11, t_s12;
	logic               f_s10, f_s11, f_s12;
	logic signed [31:0] x1p, pf;
	logic signed [63:0] x1sq_w, m_w, y1_w;

	assign x1p    = p_s10 >>> 8;
	assign x1sq_w = x1p * x1p;
	assign m_w    = p_s10 * P_C2;
	assign y1_w   = x1sq_s11 * P_C1;
	assign pf     = p_s12 + (((y1_s12 >>> 16) + x2_s12 + P_C3) >>> 4);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s10 <= msb2 ? {q2[30:0], 1'b0} : q2;
			t_s10 <= t2; f_s10 <= f2;

			x1sq_s11 <= x1sq_w[31:0];
			m_s11    <= m_w[31:0];
			p_s11 <= p_s10; t_s11 <= t_s10; f_s11 <= f_s10;

			y1_s12 <= y1_w[31:0];
			x2_s12 <= m_s11 >>> 16;
			p_s12 <= p_s11; t_s12 <= t_s11; f_s12 <= f_s11;
		end
	end

	always_comb begin
		out_v = v_s12;
		fault = f_s12;
		if (f_s12) begin
			temp = '0;
			pres = '0;
		end else begin
			temp = t_s12;
			if (pf < 32'sd0) pres = '0;
			else if (pf > PRES_MAX) pres = PRES_MAX[PRES_W-1:0];
			else pres = pf[PRES_W-1:0];
		end
	end
endmodule

@@ dv/baro_pressure_temp_compensation_unit_tb.sv @@
// Self-checking testbench for the barometric compensation unit: a directed table,
// then random calibration phases, every result checked against a built-in predictor or a fault expectation.
// Depends on bptc_pkg and baro_pressure_temp_compensation_unit.
`timescale 1ns / 1ps
module baro_pressure_temp_compensation_unit_tb;
	import bptc_pkg::*;

	localparam int LATENCY_CYCLES = 90;
	localparam int HOLD_CYCLES    = 300;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int PHASE_ITEMS    = 150;
	localparam int PHASES         = 9;

	localparam logic [63:0] DS_WORD_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
	localparam logic [63:0] DS_WORD_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
	localparam logic [63:0] DS_WORD_C = {32'd0, -16'sd8711, 16'sd2868};

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic [PRES_W-1:0] pres;
		logic              fault;
	} reading_t;

	typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		cfg_idx_t         idx;
		logic [63:0]      data;
		logic [UT_W-1:0]  ut;
		logic [UP_W-1:0]  rp;
		bit               typed;
		reading_t         exp;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [UT_W-1:0]   raw_temperature = '0;
	logic [UP_W-1:0]   raw_pressure_bytes = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [TEMP_W-1:0] temperature_tenths;
	logic [PRES_W-1:0] pressure_pa;
	logic              divide_fault;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [63:0]       cfg_data = '0;

	logic [63:0] coeff_a = '0;
	logic [63:0] coeff_b = '0;
	logic [31:0] coeff_c = '0;
	logic [1:0]  oss_setting = '0;

	reading_t  pending_readings[$];
	stim_row_t directed_rows[$];
	int        errors = 0;
	int        cycles = 0;
	bit        send_gaps = 1'b1;
	bit        pop_gaps = 1'b1;
	bit        hold_req = 1'b0;

	baro_pressure_temp_compensation_unit DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.raw_temperature(raw_temperature), .raw_pressure_bytes(raw_pressure_bytes),
		.empty(empty), .pop(pop), .temperature_tenths(temperature_tenths),
		.pressure_pa(pressure_pa), .divide_fault(divide_fault),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL baro_pressure_temp_compensation_unit");
			$finish;
		end
	end

	function automatic longint wrap32(longint x);
		return longint'($signed(x[31:0]));
	endfunction

	function automatic reading_t compensate(logic [UT_W-1:0] ut_raw, logic [UP_W-1:0] rp);
		longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
		longint x1, x2, x3, b5, b6, b6sq, b3, t, p, d;
		bit [31:0] b4, b7, up, pu, x3p, ac4u;
		int oss;
		reading_t r;
		ac1 = $signed(coeff_a[63:48]);
		ac2 = $signed(coeff_a[47:32]);
		ac3 = $signed(coeff_a[31:16]);
		ac4 = longint'(coeff_a[15:0]);
		ac5 = longint'(coeff_b[63:48]);
		ac6 = longint'(coeff_b[47:32]);
		b1 = $signed(coeff_b[31:16]);
		b2 = $signed(coeff_b[15:0]);
		mc = $signed(coeff_c[31:16]);
		md = $signed(coeff_c[15:0]);
		oss = int'(oss_setting);
		ut = longint'(ut_raw);
		r = '0;

		x1 = wrap32((ut - ac6) * ac5) >>> 15;
		d = wrap32(x1 + md);
		if (d == 0) begin
			r.fault = 1'b1;
			return r;
		end
		x2 = (mc * 2048) / d;
		b5 = wrap32(x1 + x2);
		t = wrap32(b5 + 8) >>> 4;

		b6 = wrap32(b5 - 4000);
		b6sq = wrap32(b6 * b6) >>> 12;
		x1 = wrap32(b2 * b6sq) >>> 11;
		x2 = wrap32(ac2 * b6) >>> 11;
		x3 = wrap32(x1 + x2);
		b3 = wrap32(ac1 * 4 + x3);
		b3 = wrap32(b3 * (longint'(1) << oss));
		b3 = wrap32(b3 + 2) >>> 2;

		x1 = wrap32(ac3 * b6) >>> 13;
		x2 = wrap32(b1 * b6sq) >>> 16;
		x3 = wrap32(x1 + x2 + 2) >>> 2;
		x3p = 32'(x3 + 32768);
		ac4u = 32'(ac4);
		b4 = (ac4u * x3p) >> 15;
		if (b4 == 0) begin
			r.fault = 1'b1;
			return r;
		end

		up = {8'd0, rp} >> (8 - oss);
		b7 = (up - b3[31:0]) * (32'd50000 >> oss);
		pu = (b7 < 32'h80000000) ? (b7 << 1) / b4 : (b7 / b4) << 1;
		p = wrap32(longint'(pu));

		x1 = p >>> 8;
		x1 = wrap32(x1 * x1);
		x1 = wrap32(x1 * 3038) >>> 16;
		x2 = wrap32(-7357 * p) >>> 16;
		p = wrap32(p + (wrap32(x1 + x2 + 3791) >>> 4));

		if (t > 2047) t = 2047;
		if (t < -2048) t = -2048;
		if (p < 0) p = 0;
		if (p > 131071) p = 131071;
		r.temp = t[TEMP_W-1:0];
		r.pres = p[PRES_W-1:0];
		return r;
	endfunction

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		reading_t exp;
		if (arst_n && pop && !empty) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result temp=%0d pres=%0d fault=%0b", $time,
					$signed(temperature_tenths), pressure_pa, divide_fault);
				errors++;
			end else begin
				exp = pending_readings.pop_front();
				if (exp.temp !== temperature_tenths) begin
					$display("%0t: temperature_tenths expected %0d actual %0d", $time,
						$signed(exp.temp), $signed(temperature_tenths));
					errors++;
				end
				if (exp.pres !== pressure_pa) begin
					$display("%0t: pressure_pa expected %0d actual %0d", $time,
						exp.pres, pressure_pa);
					errors++;
				end
				if (exp.fault !== divide_fault) begin
					$display("%0t: divide_fault expected %0b actual %0b", $time,
						exp.fault, divide_fault);
					errors++;
				end
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int gap;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = pop_gaps ? $urandom_range(0, 7) : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	task automatic send_reading(logic [UT_W-1:0] ut, logic [UP_W-1:0] rp, bit typed,
			reading_t typed_exp);
		int gap;
		gap = send_gaps ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		raw_temperature <= ut;
		raw_pressure_bytes <= rp;
		do @(posedge clk); while (full);
		pending_readings.push_back(typed ? typed_exp : compensate(ut, rp));
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_COEFF_A: coeff_a = data;
			CFG_COEFF_B: coeff_b = data;
			CFG_COEFF_C: coeff_c = data[31:0];
			CFG_OSS:     oss_setting = data[1:0];
			default:     ;
		endcase
	endtask

	function automatic stim_row_t cfg_row(cfg_idx_t idx, logic [63:0] data);
		stim_row_t r;
		r = '{kind: ROW_CFG, idx: idx, data: data, ut: '0, rp: '0, typed: 1'b0, exp: '0};
		return r;
	endfunction

	function automatic stim_row_t item_row(logic [UT_W-1:0] ut, logic [UP_W-1:0] rp,
			bit typed, reading_t exp);
		stim_row_t r;
		r = '{kind: ROW_ITEM, idx: CFG_COEFF_A, data: '0, ut: ut, rp: rp, typed: typed,
			exp: exp};
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [15:0] nudge(logic [15:0] v);
		return v ^ 16'($urandom_range(0, 255));
	endfunction

	initial begin
		reading_t fault_exp;
		logic [63:0] wa, wb, wc;
		fault_exp = '{temp: '0, pres: '0, fault: 1'b1};

		// zero calibration after reset: zero temperature divisor
		directed_rows.push_back(item_row(16'h0000, 24'h000000, 1'b1, fault_exp));
		directed_rows.push_back(item_row(16'hFFFF, 24'hFFFFFF, 1'b1, fault_exp));
		directed_rows.push_back(cfg_row(CFG_COEFF_A, DS_WORD_A));
		directed_rows.push_back(cfg_row(CFG_COEFF_B, DS_WORD_B));
		directed_rows.push_back(cfg_row(CFG_COEFF_C, DS_WORD_C));
		directed_rows.push_back(cfg_row(CFG_OSS, 64'd0));
		directed_rows.push_back(item_row(16'd27898, 24'h5D2300, 1'b0, '0));
		directed_rows.push_back(item_row(16'h0000, 24'h000000, 1'b0, '0));
		directed_rows.push_back(item_row(16'hFFFF, 24'hFFFFFF, 1'b0, '0));
		directed_rows.push_back(item_row(16'h0000, 24'hFFFFFF, 1'b0, '0));
		directed_rows.push_back(item_row(16'hFFFF, 24'h000000, 1'b0, '0));
		directed_rows.push_back(item_row(16'h8000, 24'h800000, 1'b0, '0));
		directed_rows.push_back(cfg_row(CFG_OSS, 64'hFFFF_FFFF_FFFF_FFFF));
		directed_rows.push_back(item_row(16'd27898, 24'h5D2300, 1'b0, '0));
		directed_rows.push_back(item_row(16'hFFFF, 24'hFFFFFF, 1'b0, '0));
		directed_rows.push_back(item_row(16'h0000, 24'h000000, 1'b0, '0));
		// zero pressure divisor
		directed_rows.push_back(cfg_row(CFG_COEFF_A, {DS_WORD_A[63:16], 16'd0}));
		directed_rows.push_back(item_row(16'd27898, 24'h5D2300, 1'b1, fault_exp));
		directed_rows.push_back(item_row(16'hFFFF, 24'hFFFFFF, 1'b1, fault_exp));
		// all-ones calibration
		directed_rows.push_back(cfg_row(CFG_COEFF_A, 64'hFFFF_FFFF_FFFF_FFFF));
		directed_rows.push_back(cfg_row(CFG_COEFF_B, 64'hFFFF_FFFF_FFFF_FFFF));
		directed_rows.push_back(cfg_row(CFG_COEFF_C, 64'hFFFF_FFFF_FFFF_FFFF));
		directed_rows.push_back(item_row(16'h0000, 24'h000000, 1'b0, '0));
		directed_rows.push_back(item_row(16'hFFFF, 24'hFFFFFF, 1'b0, '0));
		directed_rows.push_back(item_row(16'h1234, 24'hABCDEF, 1'b0, '0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_reading(directed_rows[i].ut, directed_rows[i].rp,
					directed_rows[i].typed, directed_rows[i].exp);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph % 3 == 0) begin
				wa = rand64();
				wb = rand64();
				wc = rand64();
			end else begin
				wa = {nudge(DS_WORD_A[63:48]), nudge(DS_WORD_A[47:32]),
					nudge(DS_WORD_A[31:16]), nudge(DS_WORD_A[15:0])};
				wb = {nudge(DS_WORD_B[63:48]), nudge(DS_WORD_B[47:32]),
					nudge(DS_WORD_B[31:16]), nudge(DS_WORD_B[15:0])};
				wc = {$urandom(), nudge(DS_WORD_C[31:16]), nudge(DS_WORD_C[15:0])};
			end
			write_reg(CFG_COEFF_A, wa);
			write_reg(CFG_COEFF_B, wb);
			write_reg(CFG_COEFF_C, wc);
			write_reg(CFG_OSS, {rand64()} & ~64'd3 | 64'(ph % 4));
			send_gaps = (ph % 3 != 1);
			pop_gaps = (ph % 3 != 1);
			if (ph == 2) hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_reading(16'($urandom()), 24'($urandom()), 1'b0, '0);
		end

		drain();
		if (errors == 0) begin
			$display("PASS baro_pressure_temp_compensation_unit");
		end else begin
			$display("FAIL baro_pressure_temp_compensation_unit");
		end
		$finish;
	end
endmodule
